FILE: hdl/bf16rdp_pkg.sv
// ----------------------------------------------------------------------------
// bf16rdp_pkg: shared constants and arithmetic for the bf16 row dot product
// Holds the fp32 encodings and the flush-to-zero multiply and add functions.
// ----------------------------------------------------------------------------
package bf16rdp_pkg;

    localparam int          OUT_DEPTH_DEFAULT = 4;
    localparam logic [31:0] FP32_QNAN         = 32'h7FC0_0000;
    localparam logic [31:0] FP32_POS_ZERO     = 32'h0000_0000;
    localparam logic [7:0]  EXP_MAX           = 8'hFF;

    // Exact bf16 x bf16 product as fp32; subnormals flush, NaN is canonical.
    function automatic logic [31:0] bf16_mul(input logic [15:0] a, input logic [15:0] b);
        logic              sg;
        logic              a_z;
        logic              b_z;
        logic              a_i;
        logic              b_i;
        logic              a_n;
        logic              b_n;
        logic [15:0]       p;
        logic [14:0]       frac;
        logic signed [9:0] e;
        logic [31:0]       res;
        sg  = a[15] ^ b[15];
        a_z = (a[14:7] == 8'h00);
        b_z = (b[14:7] == 8'h00);
        a_i = (a[14:7] == EXP_MAX) && (a[6:0] == 7'h00);
        b_i = (b[14:7] == EXP_MAX) && (b[6:0] == 7'h00);
        a_n = (a[14:7] == EXP_MAX) && (a[6:0] != 7'h00);
        b_n = (b[14:7] == EXP_MAX) && (b[6:0] != 7'h00);
        p   = {1'b1, a[6:0]} * {1'b1, b[6:0]};
        e   = signed'({2'b00, a[14:7]}) + signed'({2'b00, b[14:7]}) - 10'sd127;
        if (p[15])
        begin
            frac = p[14:0];
            e    = e + 10'sd1;
        end
        else
        begin
            frac = {p[13:0], 1'b0};
        end
        if (a_n || b_n || (a_i && b_z) || (b_i && a_z))
        begin
            res = FP32_QNAN;
        end
        else if (a_i || b_i)
        begin
            res = {sg, EXP_MAX, 23'h0};
        end
        else if (a_z || b_z || (e <= 10'sd0))
        begin
            res = {sg, 31'h0};
        end
        else if (e >= 10'sd255)
        begin
            res = {sg, EXP_MAX, 23'h0};
        end
        else
        begin
            res = {sg, e[7:0], frac, 8'h00};
        end
        return res;
    endfunction

    // Position of the leading one in a 27-bit word, counted from the top.
    function automatic logic [4:0] lead_zeros27(input logic [26:0] v);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < 27; i++)
        begin
            if (v[i])
            begin
                n = 5'(26 - i);
            end
        end
        return n;
    endfunction

    // fp32 add of two flushed operands, round to nearest even, result flushed.
    function automatic logic [31:0] fp32_add(input logic [31:0] x, input logic [31:0] y);
        logic [31:0]       bg;
        logic [31:0]       sm;
        logic [7:0]        d;
        logic [26:0]       mb;
        logic [26:0]       ms;
        logic [26:0]       msh;
        logic [26:0]       n;
        logic [27:0]       s;
        logic [4:0]        lz;
        logic [24:0]       r;
        logic              st;
        logic              inc;
        logic signed [9:0] e;
        logic [31:0]       res;
        if (x[30:0] >= y[30:0])
        begin
            bg = x;
            sm = y;
        end
        else
        begin
            bg = y;
            sm = x;
        end
        d   = bg[30:23] - sm[30:23];
        mb  = {1'b1, bg[22:0], 3'b000};
        ms  = {1'b1, sm[22:0], 3'b000};
        msh = 27'h0;
        st  = 1'b1;
        if (d < 8'd27)
        begin
            msh = ms >> d[4:0];
            st  = |(ms & ~({27{1'b1}} << d[4:0]));
        end
        msh[0] = msh[0] | st;
        e = signed'({2'b00, bg[30:23]});
        n = 27'h0;
        if (bg[31] == sm[31])
        begin
            s = {1'b0, mb} + {1'b0, msh};
            if (s[27])
            begin
                n = {s[27:2], s[1] | s[0]};
                e = e + 10'sd1;
            end
            else
            begin
                n = s[26:0];
            end
        end
        else
        begin
            s  = {1'b0, mb} - {1'b0, msh};
            lz = lead_zeros27(s[26:0]);
            n  = s[26:0] << lz;
            e  = e - signed'({5'b00000, lz});
        end
        inc = n[2] & (n[1] | n[0] | n[3]);
        r   = {1'b0, n[26:3]} + {24'h0, inc};
        if (r[24])
        begin
            e = e + 10'sd1;
        end
        if ((x[30:23] == EXP_MAX && x[22:0] != 23'h0) ||
            (y[30:23] == EXP_MAX && y[22:0] != 23'h0))
        begin
            res = FP32_QNAN;
        end
        else if (x[30:23] == EXP_MAX && y[30:23] == EXP_MAX)
        begin
            res = (x[31] == y[31]) ? x : FP32_QNAN;
        end
        else if (bg[30:23] == EXP_MAX)
        begin
            res = bg;
        end
        else if (sm[30:23] == 8'h00)
        begin
            if (bg[30:23] == 8'h00)
            begin
                res = {x[31] & y[31], 31'h0};
            end
            else
            begin
                res = bg;
            end
        end
        else if (bg[31] != sm[31] && s[26:0] == 27'h0)
        begin
            res = FP32_POS_ZERO;
        end
        else if (e >= 10'sd255)
        begin
            res = {bg[31], EXP_MAX, 23'h0};
        end
        else if (e <= 10'sd0)
        begin
            res = {bg[31], 31'h0};
        end
        else
        begin
            res = {bg[31], e[7:0], r[22:0]};
        end
        return res;
    endfunction

endpackage

FILE: hdl/bf16_row_dot_product_top.sv
// ----------------------------------------------------------------------------
// bf16_row_dot_product_top: streaming bf16 row dot product with fp32 sum
// Multiplies element pairs, accumulates per row, emits the sum on end of row.
// ----------------------------------------------------------------------------
// The last request of a row passes stage one and stage two, and its row sum is
// then written into the output queue, which offers it on m_tvalid.
// Throughput: one request per cycle while s_tready is high; the fp32 add back
// into the accumulator is combinational and closes through acc_reg alone, and a
// small output queue keeps input flowing while results wait. Reset clears the
// accumulator to positive zero and empties the pipeline and the output queue.
module bf16_row_dot_product_top
    import bf16rdp_pkg::*;
#(
    parameter int OUT_DEPTH = OUT_DEPTH_DEFAULT  // output queue entries, at least 3
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] out_value, [31:16] grad_value
    input  logic        s_tlast,   // end_of_row
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] row_sum
);

    localparam int PW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;
    localparam int CW = $clog2(OUT_DEPTH + 1) + 1;

    // Stage one holds the raw request, stage two the fp32 product.
    logic        v1_reg;
    logic [15:0] a1_reg;
    logic [15:0] g1_reg;
    logic        e1_reg;
    logic        v2_reg;
    logic [31:0] p2_reg;
    logic        e2_reg;
    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [31:0] sum;

    // The output queue is the result register; it holds finished row sums.
    logic [31:0]   mem_reg [OUT_DEPTH];
    logic [PW-1:0] wptr_reg;
    logic [PW-1:0] rptr_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] pending;
    logic          push;
    logic          pop;
    logic          accept;

    // Count every row sum that is queued or still in flight, so a result can
    // always find a free entry and the pipeline never has to stall. A new
    // request is taken only while one more row sum would still fit.
    assign pending  = cnt_reg + CW'(v1_reg & e1_reg) + CW'(v2_reg & e2_reg);
    assign s_tready = (pending < CW'(OUT_DEPTH));
    assign accept   = s_tvalid & s_tready;
    assign push     = v2_reg & e2_reg;
    assign pop      = m_tvalid & m_tready;
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = mem_reg[rptr_reg];

    assign sum = fp32_add(acc_reg, p2_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (v2_reg)
        begin
            acc_next = e2_reg ? FP32_POS_ZERO : sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            e1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            e2_reg   <= 1'b0;
            acc_reg  <= FP32_POS_ZERO;
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            v1_reg  <= accept;
            e1_reg  <= accept & s_tlast;
            v2_reg  <= v1_reg;
            e2_reg  <= v1_reg & e1_reg;
            acc_reg <= acc_next;
            if (push)
            begin
                wptr_reg <= (wptr_reg == PW'(OUT_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == PW'(OUT_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a1_reg <= s_tdata[15:0];
            g1_reg <= s_tdata[31:16];
        end
        p2_reg <= bf16_mul(a1_reg, g1_reg);
        if (push)
        begin
            mem_reg[wptr_reg] <= sum;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(OUT_DEPTH))
        else $error("output queue overfilled");

    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && e2_reg) |=> (acc_reg == FP32_POS_ZERO))
        else $error("accumulator not cleared after end of row");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg < CW'(OUT_DEPTH)) || pop)
        else $error("row sum written into a full queue");

    a_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (!push && !pop) |=> $stable(cnt_reg))
        else $error("queue count moved without a push or pop");

endmodule

FILE: tb/tb_bf16_row_dot_product_top.sv
// ----------------------------------------------------------------------------
// tb_bf16_row_dot_product_top: self-checking bench for the bf16 row dot product
// Streams element pairs with row marks, predicts each fp32 row sum with an
// independent model built on double-precision reals, and compares every row
// sum the block returns, under random idling and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bf16_row_dot_product_top;
    import bf16rdp_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_START    = 800;    // receiver holds off m_tready here
    localparam int HOLD_CYCLES   = 400;
    localparam int CALM_START    = 1600;   // no idling on either side here
    localparam int CALM_END      = 2100;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic [15:0] out_value;
        logic [15:0] grad_value;
        logic        end_of_row;
    } elem_pair_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;      // [15:0] out_value, [31:16] grad_value
    logic        s_tlast;      // end_of_row
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;      // [31:0] row_sum

    elem_pair_t  pending_pairs[$];
    logic [31:0] expected_sums[$];
    logic [31:0] row_acc;       // predicted running sum of the current row
    int          cycle_count = 0;
    int          error_count = 0;
    int          hold_left;     // cycles of the receiver hold-off still to go
    logic        stimulus_ready;

    bf16_row_dot_product_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Floating-point predictor. Flushed fp32 operands are exact in double,
    // and a double product or sum of two fp32 values rounds to the same
    // fp32 result as a direct fp32 operation, so reals carry the arithmetic
    // and a hand-written round-to-nearest-even narrows the result.
    // ------------------------------------------------------------------
    function automatic logic is_nan32(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'h0);
    endfunction

    function automatic logic is_inf32(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] == 23'h0);
    endfunction

    // Widen a bf16 pattern to fp32 with subnormals flushed to signed zero.
    function automatic logic [31:0] widen_flushed(input logic [15:0] h);
        logic [31:0] b;
        b = {h, 16'h0};
        if (b[30:23] == 8'h00)
        begin
            b = {b[31], 31'h0};
        end
        return b;
    endfunction

    function automatic real fp32_as_real(input logic [31:0] b);
        logic [10:0] e64;
        if (b[30:23] == 8'h00)
        begin
            return $bitstoreal({b[31], 63'h0});
        end
        e64 = 11'(b[30:23]) + 11'd896;
        return $bitstoreal({b[31], e64, b[22:0], 29'h0});
    endfunction

    // Narrow a finite double to fp32 bits: nearest even, overflow to
    // infinity, and anything below the normal range to signed zero.
    function automatic logic [31:0] real_to_fp32(input real r);
        logic [63:0] d;
        logic [52:0] mant;
        logic [24:0] rounded;
        logic        round_up;
        int          exp32;
        d = $realtobits(r);
        if (d[62:52] == 11'h0)
        begin
            return {d[63], 31'h0};
        end
        exp32    = int'(d[62:52]) - 1023 + 127;
        mant     = {1'b1, d[51:0]};
        round_up = mant[28] & ((|mant[27:0]) | mant[29]);
        rounded  = {1'b0, mant[52:29]} + 25'(round_up);
        if (rounded[24])
        begin
            exp32 = exp32 + 1;
            rounded = rounded >> 1;
        end
        if (exp32 >= 255)
        begin
            return {d[63], 8'hFF, 23'h0};
        end
        if (exp32 <= 0)
        begin
            return {d[63], 31'h0};
        end
        return {d[63], exp32[7:0], rounded[22:0]};
    endfunction

    function automatic logic [31:0] mul_flushed(input logic [31:0] a, input logic [31:0] b);
        logic sg;
        logic a_zero;
        logic b_zero;
        sg     = a[31] ^ b[31];
        a_zero = (a[30:0] == 31'h0);
        b_zero = (b[30:0] == 31'h0);
        if (is_nan32(a) || is_nan32(b) || (is_inf32(a) && b_zero) || (is_inf32(b) && a_zero))
        begin
            return FP32_QNAN;
        end
        if (is_inf32(a) || is_inf32(b))
        begin
            return {sg, 8'hFF, 23'h0};
        end
        if (a_zero || b_zero)
        begin
            return {sg, 31'h0};
        end
        return real_to_fp32(fp32_as_real(a) * fp32_as_real(b));
    endfunction

    function automatic logic [31:0] add_flushed(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] s;
        real         rs;
        if (is_nan32(x) || is_nan32(y))
        begin
            return FP32_QNAN;
        end
        if (is_inf32(x) && is_inf32(y))
        begin
            return (x[31] == y[31]) ? x : FP32_QNAN;
        end
        if (is_inf32(x))
        begin
            return x;
        end
        if (is_inf32(y))
        begin
            return y;
        end
        rs = fp32_as_real(x) + fp32_as_real(y);
        s  = real_to_fp32(rs);
        // An exact zero sum is negative only when both addends are; a tiny
        // nonzero sum that flushes keeps its own sign.
        if (rs == 0.0)
        begin
            s = {x[31] & y[31], 31'h0};
        end
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    // A bf16 pattern drawn from weighted classes so that specials show up
    // regularly, while most values stay near one to keep row sums lively.
    function automatic logic [15:0] random_bf16();
        int   pick;
        logic sg;
        sg   = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 4)
        begin
            return {sg, 15'h0};
        end
        if (pick < 7)
        begin
            return {sg, 8'h00, 7'($urandom_range(1, 127))};
        end
        if (pick < 9)
        begin
            return {sg, 8'hFF, 7'h00};
        end
        if (pick < 11)
        begin
            return {sg, 8'hFF, 7'($urandom_range(1, 127))};
        end
        if (pick < 14)
        begin
            return {sg, ($urandom_range(0, 1) != 0) ? 8'hFE : 8'h01, 7'($urandom)};
        end
        if (pick < 20)
        begin
            return 16'($urandom);
        end
        return {sg, 8'($urandom_range(118, 136)), 7'($urandom)};
    endfunction

    task automatic queue_pair(input logic [15:0] o, input logic [15:0] g, input logic last);
        elem_pair_t p;
        p.out_value  = o;
        p.grad_value = g;
        p.end_of_row = last;
        pending_pairs.push_back(p);
    endtask

    function automatic logic side_idles();
        if (cycle_count >= CALM_START && cycle_count < CALM_END)
        begin
            return 1'b0;
        end
        return ($urandom_range(0, 99) < 31);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus: a directed set of rows, then random rows.
    // ------------------------------------------------------------------
    initial
    begin
        int items;
        int row_len;
        clk            = 1'b0;
        rst_n          = 1'b0;
        stimulus_ready = 1'b0;

        // Single-element rows: ones, the largest finite values, a NaN and zeros.
        queue_pair(16'h3F80, 16'h3F80, 1'b1);
        queue_pair(16'h7F7F, 16'h7F7F, 1'b1);
        queue_pair(16'hFFFF, 16'hFFFF, 1'b1);
        queue_pair(16'h0000, 16'h0000, 1'b1);
        // Subnormal operands flush to signed zero; zeros of opposite sign add up to
        // positive zero, and two negative zeros also sum to positive zero here.
        queue_pair(16'h0001, 16'h3F80, 1'b0);
        queue_pair(16'h807F, 16'h3F80, 1'b1);
        queue_pair(16'h8000, 16'h3F80, 1'b0);
        queue_pair(16'h8000, 16'h3F80, 1'b1);
        // Product below the normal range flushes to zero.
        queue_pair(16'h0080, 16'h0080, 1'b1);
        // Product overflow to infinity, then infinity minus infinity.
        queue_pair(16'h7F00, 16'h7F00, 1'b1);
        queue_pair(16'h7F80, 16'h3F80, 1'b0);
        queue_pair(16'hFF80, 16'h3F80, 1'b1);
        // Infinity times zero, and a NaN that persists through the row.
        queue_pair(16'h7F80, 16'h0000, 1'b1);
        queue_pair(16'h7FC1, 16'h3F80, 1'b0);
        queue_pair(16'h3F80, 16'h4000, 1'b1);
        // Cancellation to exact zero, then ties that exercise rounding.
        queue_pair(16'h4040, 16'h3F80, 1'b0);
        queue_pair(16'hC040, 16'h3F80, 1'b1);
        queue_pair(16'h4B80, 16'h3F80, 1'b0);
        queue_pair(16'h3F00, 16'h3F80, 1'b0);
        queue_pair(16'h3F80, 16'h3F80, 1'b1);
        // Sum overflow from two large finite products.
        queue_pair(16'h7F7F, 16'h3F80, 1'b0);
        queue_pair(16'h7F7F, 16'h3F80, 1'b1);
        // A negative sum below the normal range flushes to negative zero.
        queue_pair(16'h80C0, 16'h3F80, 1'b0);
        queue_pair(16'h0080, 16'h3F80, 1'b1);

        items = 0;
        while (items < 1750)
        begin
            row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
            for (int i = 0; i < row_len; i++)
            begin
                queue_pair(random_bf16(), random_bf16(), i == row_len - 1);
            end
            items = items + row_len;
        end
        stimulus_ready = 1'b1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_pairs.size() == 0 && !s_tvalid && expected_sums.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: presents queued pairs, keeps a request steady until it is
    // taken, and updates the predicted row sum on every accepted request.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic        taken;
        logic [31:0] next_acc;
        elem_pair_t  p;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 32'h0;
            s_tlast  <= 1'b0;
            row_acc  = FP32_POS_ZERO;
        end
        else
        begin
            taken = s_tvalid && s_tready;
            if (taken)
            begin
                p = pending_pairs.pop_front();
                next_acc = add_flushed(row_acc,
                    mul_flushed(widen_flushed(p.out_value), widen_flushed(p.grad_value)));
                if (p.end_of_row)
                begin
                    expected_sums.push_back(next_acc);
                    row_acc = FP32_POS_ZERO;
                end
                else
                begin
                    row_acc = next_acc;
                end
            end
            if (taken || !s_tvalid)
            begin
                if (stimulus_ready && pending_pairs.size() != 0 && !side_idles())
                begin
                    p = pending_pairs[0];
                    s_tvalid <= 1'b1;
                    s_tdata  <= {p.grad_value, p.out_value};
                    s_tlast  <= p.end_of_row;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: drives m_tready, with one long hold-off that lets the block
    // fill up and stall its input, and checks each returned row sum.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic [31:0] want;
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_sums.size() == 0)
                begin
                    $display("%0t: unexpected row sum, expected none, actual %h",
                             $time, m_tdata);
                    error_count = error_count + 1;
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (m_tdata !== want)
                    begin
                        $display("%0t: row_sum mismatch, expected %h, actual %h",
                                 $time, want, m_tdata);
                        error_count = error_count + 1;
                    end
                end
            end
            if (hold_left > 0)
            begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (cycle_count == HOLD_START)
            begin
                m_tready  <= 1'b0;
                hold_left <= HOLD_CYCLES - 1;
            end
            else
            begin
                m_tready <= !side_idles();
            end
        end
    end

    // Cycle counter and watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule

FILE: filelist.f
hdl/bf16rdp_pkg.sv
hdl/bf16_row_dot_product_top.sv
tb/tb_bf16_row_dot_product_top.sv
